// ===== rtl/core/rlc_pkg.sv =====
// rlc_pkg: widths, limits and codes for the raster layer compositor
// no dependencies
package rlc_pkg;

    localparam int BLOCK_PIXELS = 4096;
    localparam int MAX_LAYERS   = 1024;

    localparam int IDX_W    = $clog2(BLOCK_PIXELS);
    localparam int SAMPLE_W = 32;
    localparam int ACC_W    = 42;
    localparam int CNT_W    = 11;
    localparam int COUNT_CAP_I = (MAX_LAYERS > 2047) ? 2047 : MAX_LAYERS;
    localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(COUNT_CAP_I);

    // one quotient bit per divider stage
    localparam int DIV_STEPS = ACC_W;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        MODE_MEAN = 2'd0,
        MODE_MIN  = 2'd1,
        MODE_MAX  = 2'd2,
        MODE_ALT  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE  = 2'd0,
        REG_VMIN  = 2'd1,
        REG_VMAX  = 2'd2,
        REG_NONE  = 2'd3
    } reg_idx_t;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

endpackage

// ===== rtl/core/raster_layer_composite.sv =====
// raster_layer_composite: per-pixel mean / min / max over a stream of raster layers
// depends on rlc_pkg; holds the 4096-entry pixel store and a bit-serial pipelined divider

// Takes one pixel sample per clock and returns one result per clock for items
// flagged last layer. An item moves through a capture stage (store read, range
// check), an update stage (forwarding, accumulate, store write), a sign stage,
// 42 divider stages (one quotient bit each) and the output register. The single
// read and write port of the pixel store sets the rate at one item per cycle; the
// whole pipeline holds while the output register is full and not taken. The store
// has no clearing pass: a first-layer item starts its pixel afresh.
module raster_layer_composite (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pixel_index [11:0], sample [43:12], zero fill
    input  logic [rlc_pkg::S_TDATA_W-1:0] s_tdata,
    // first_layer
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_index [11:0], combined_value [43:12], valid_count [54:44], zero fill
    output logic [rlc_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rlc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import rlc_pkg::*;

    // configuration
    mode_t                      mode_reg;
    logic signed [SAMPLE_W-1:0] vmin_reg, vmax_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_MEAN;
            vmin_reg <= {1'b1, {(SAMPLE_W-1){1'b0}}};
            vmax_reg <= {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (cfg_valid) begin
            case (reg_idx_t'(cfg_index))
                REG_MODE: mode_reg <= mode_t'(cfg_data[1:0]);
                REG_VMIN: vmin_reg <= cfg_data;
                REG_VMAX: vmax_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    logic adv;
    logic m_valid_reg;
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    logic [IDX_W-1:0]           in_idx;
    logic signed [SAMPLE_W-1:0] in_sample;
    assign in_idx    = s_tdata[IDX_W-1:0];
    assign in_sample = s_tdata[IDX_W +: SAMPLE_W];

    // pixel store: {count, accumulator}
    logic [CNT_W+ACC_W-1:0] mem [BLOCK_PIXELS];
    logic [CNT_W+ACC_W-1:0] mem_q_reg;

    // capture stage
    logic                       a_valid_reg, a_first_reg, a_last_reg, a_inrange_reg;
    logic [IDX_W-1:0]           a_idx_reg;
    logic signed [SAMPLE_W-1:0] a_sample_reg;
    mode_t                      a_mode_reg;

    // update stage
    logic                       b_valid_reg, b_last_reg, b_mean_reg;
    logic [IDX_W-1:0]           b_idx_reg;
    logic signed [ACC_W-1:0]    b_acc_reg;
    logic [CNT_W-1:0]           b_cnt_reg;

    // update logic
    logic                    a_mean, fwd;
    logic signed [ACC_W-1:0] acc_in, acc_next, s_ext;
    logic [CNT_W-1:0]        cnt_in, cnt_next;
    logic signed [ACC_W:0]   sum;

    always_comb begin
        a_mean = (a_mode_reg == MODE_MEAN) || (a_mode_reg == MODE_ALT);
        fwd    = b_valid_reg && (b_idx_reg == a_idx_reg);
        if (a_first_reg) begin
            acc_in = '0;
            cnt_in = '0;
        end else if (fwd) begin
            acc_in = b_acc_reg;
            cnt_in = b_cnt_reg;
        end else begin
            acc_in = mem_q_reg[ACC_W-1:0];
            cnt_in = mem_q_reg[CNT_W+ACC_W-1:ACC_W];
        end
        s_ext    = ACC_W'(a_sample_reg);
        sum      = (ACC_W+1)'(acc_in) + (ACC_W+1)'(s_ext);
        acc_next = acc_in;
        cnt_next = cnt_in;
        if (a_inrange_reg) begin
            if (cnt_in == '0) begin
                acc_next = s_ext;
                cnt_next = CNT_W'(1);
            end else if (a_mean) begin
                if (cnt_in < COUNT_CAP) begin
                    // saturate when the top two sum bits disagree
                    if (sum[ACC_W] != sum[ACC_W-1])
                        acc_next = sum[ACC_W] ? ACC_MIN : ACC_MAX;
                    else
                        acc_next = sum[ACC_W-1:0];
                    cnt_next = cnt_in + CNT_W'(1);
                end
            end else begin
                if (a_mode_reg == MODE_MIN && s_ext < acc_in)
                    acc_next = s_ext;
                if (a_mode_reg == MODE_MAX && s_ext > acc_in)
                    acc_next = s_ext;
                if (cnt_in < COUNT_CAP)
                    cnt_next = cnt_in + CNT_W'(1);
            end
        end else if (cnt_in == '0) begin
            acc_next = s_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mem_q_reg <= mem[in_idx];
            if (a_valid_reg)
                mem[a_idx_reg] <= {cnt_next, acc_next};
        end
    end

    // divider pipeline, stage 0 holds magnitude and divisor
    logic               d_valid_reg [DIV_STEPS+1];
    logic               d_neg_reg   [DIV_STEPS+1];
    logic [IDX_W-1:0]   d_idx_reg   [DIV_STEPS+1];
    logic [CNT_W-1:0]   d_cnt_reg   [DIV_STEPS+1];
    logic [CNT_W-1:0]   d_div_reg   [DIV_STEPS+1];
    logic [CNT_W-1:0]   d_rem_reg   [DIV_STEPS+1];
    logic [ACC_W-1:0]   d_work_reg  [DIV_STEPS+1];

    logic [CNT_W:0]     trial [DIV_STEPS+1];
    logic               qbit  [DIV_STEPS+1];

    always_comb begin
        trial[0] = '0;
        qbit[0]  = 1'b0;
        for (int i = 1; i <= DIV_STEPS; i++) begin
            trial[i] = {d_rem_reg[i-1], d_work_reg[i-1][ACC_W-1]};
            qbit[i]  = trial[i] >= {1'b0, d_div_reg[i-1]};
        end
    end

    logic                    b_neg;
    logic [ACC_W-1:0]        b_mag;
    assign b_neg = b_acc_reg[ACC_W-1];
    assign b_mag = b_neg ? ACC_W'(-b_acc_reg) : ACC_W'(b_acc_reg);

    // output stage
    logic [ACC_W-1:0]           q;
    logic                       q_neg;
    logic signed [SAMPLE_W-1:0] result;
    logic [IDX_W-1:0]           m_idx_reg;
    logic signed [SAMPLE_W-1:0] m_value_reg;
    logic [CNT_W-1:0]           m_cnt_reg;

    always_comb begin
        q     = d_work_reg[DIV_STEPS];
        q_neg = d_neg_reg[DIV_STEPS];
        if (!q_neg && q > ACC_W'({1'b0, {(SAMPLE_W-1){1'b1}}}))
            result = {1'b0, {(SAMPLE_W-1){1'b1}}};
        else if (q_neg && q > ACC_W'({1'b1, {(SAMPLE_W-1){1'b0}}}))
            result = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else if (q_neg)
            result = SAMPLE_W'(-q);
        else
            result = q[SAMPLE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i <= DIV_STEPS; i++)
                d_valid_reg[i] <= 1'b0;
        end else if (adv) begin
            a_valid_reg   <= s_tvalid;
            a_idx_reg     <= in_idx;
            a_sample_reg  <= in_sample;
            a_first_reg   <= s_tuser;
            a_last_reg    <= s_tlast;
            a_mode_reg    <= mode_reg;
            a_inrange_reg <= (vmin_reg <= in_sample) && (in_sample <= vmax_reg);

            b_valid_reg <= a_valid_reg;
            b_idx_reg   <= a_idx_reg;
            b_acc_reg   <= acc_next;
            b_cnt_reg   <= cnt_next;
            b_last_reg  <= a_last_reg;
            b_mean_reg  <= a_mean;

            // only last-layer items go on to the divider
            d_valid_reg[0] <= b_valid_reg && b_last_reg;
            d_neg_reg[0]   <= b_neg;
            d_idx_reg[0]   <= b_idx_reg;
            d_cnt_reg[0]   <= b_cnt_reg;
            d_div_reg[0]   <= (b_mean_reg && b_cnt_reg != '0) ? b_cnt_reg : CNT_W'(1);
            d_rem_reg[0]   <= '0;
            d_work_reg[0]  <= b_mag;
            for (int i = 1; i <= DIV_STEPS; i++) begin
                d_valid_reg[i] <= d_valid_reg[i-1];
                d_neg_reg[i]   <= d_neg_reg[i-1];
                d_idx_reg[i]   <= d_idx_reg[i-1];
                d_cnt_reg[i]   <= d_cnt_reg[i-1];
                d_div_reg[i]   <= d_div_reg[i-1];
                d_rem_reg[i]   <= qbit[i] ? CNT_W'(trial[i] - {1'b0, d_div_reg[i-1]})
                                          : trial[i][CNT_W-1:0];
                d_work_reg[i]  <= {d_work_reg[i-1][ACC_W-2:0], qbit[i]};
            end

            m_valid_reg <= d_valid_reg[DIV_STEPS];
            m_idx_reg   <= d_idx_reg[DIV_STEPS];
            m_cnt_reg   <= d_cnt_reg[DIV_STEPS];
            m_value_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-IDX_W-SAMPLE_W-CNT_W){1'b0}},
                       m_cnt_reg, m_value_reg, m_idx_reg};

endmodule

// ===== sim/testbench.sv =====
// testbench for raster_layer_composite: drives pixel samples and register writes,
// predicts every combined result in a scoreboard class and checks it field by field
// depends on rlc_pkg and the raster_layer_composite rtl
`timescale 1ns / 1ps

typedef struct {
    logic [11:0] idx;
    logic [31:0] value;
    logic [10:0] count;
} pixel_result_t;

class composite_scoreboard;
    rlc_pkg::mode_t mode;
    longint vmin, vmax;
    longint acc_store[4096];
    int unsigned cnt_store[4096];
    bit cleared[4096];
    pixel_result_t pending[$];
    int unsigned errors;

    function new();
        mode = rlc_pkg::MODE_MEAN;
        vmin = -64'sd2147483648;
        vmax = 64'sd2147483647;
        errors = 0;
    endfunction

    function void note_register(rlc_pkg::reg_idx_t ri, logic [31:0] d);
        case (ri)
            rlc_pkg::REG_MODE: mode = rlc_pkg::mode_t'(d[1:0]);
            rlc_pkg::REG_VMIN: vmin = longint'($signed(d));
            rlc_pkg::REG_VMAX: vmax = longint'($signed(d));
            default: ;
        endcase
    endfunction

    function void note_item(logic [11:0] idx, logic [31:0] raw, bit first, bit last);
        longint s, a, v;
        longint amax, amin;
        int unsigned c;
        bit mean;
        pixel_result_t r;
        amax = (64'sd1 <<< 41) - 1;
        amin = -(64'sd1 <<< 41);
        s = longint'($signed(raw));
        mean = (mode == rlc_pkg::MODE_MEAN) || (mode == rlc_pkg::MODE_ALT);
        if (first) begin
            acc_store[idx] = 0;
            cnt_store[idx] = 0;
            cleared[idx] = 1;
        end
        a = acc_store[idx];
        c = cnt_store[idx];
        if (s >= vmin && s <= vmax) begin
            if (c == 0) begin
                a = s;
                c = 1;
            end else if (mean) begin
                if (c < rlc_pkg::COUNT_CAP_I) begin
                    a = a + s;
                    if (a > amax) a = amax;
                    if (a < amin) a = amin;
                    c++;
                end
            end else begin
                if (mode == rlc_pkg::MODE_MIN && s < a) a = s;
                if (mode == rlc_pkg::MODE_MAX && s > a) a = s;
                if (c < rlc_pkg::COUNT_CAP_I) c++;
            end
        end else if (c == 0) begin
            a = s;
        end
        acc_store[idx] = a;
        cnt_store[idx] = c;
        if (last) begin
            v = a;
            // signed division truncates toward zero
            if (mean && c > 0) v = a / longint'(c);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            r.idx = idx;
            r.value = v[31:0];
            r.count = c[10:0];
            pending = {pending, r};
        end
    endfunction

    function void check_result(logic [55:0] td);
        pixel_result_t e;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, td);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (td[11:0] !== e.idx) begin
            $display("%0t: out_index expected %0d actual %0d", $time, e.idx, td[11:0]);
            errors++;
        end
        if (td[43:12] !== e.value) begin
            $display("%0t: combined_value expected %h actual %h", $time, e.value, td[43:12]);
            errors++;
        end
        if (td[54:44] !== e.count) begin
            $display("%0t: valid_count expected %0d actual %0d", $time, e.count, td[54:44]);
            errors++;
        end
    endfunction
endclass

module testbench;
    import rlc_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 0;
    logic s_tlast = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    composite_scoreboard sb;
    bit idle_on = 1;
    int unsigned stall_left = 0;
    int unsigned gap_left = 0;
    int unsigned sent = 0;

    raster_layer_composite uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // receiver stalls in bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready = (stall_left == 0);
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18);
            m_tready = 0;
        end else begin
            m_tready = 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(logic [11:0] idx, logic [31:0] smp, bit first, bit last);
        if (idle_on && gap_left == 0 && $urandom_range(0, 9) == 0)
            gap_left = $urandom_range(1, 18);
        while (gap_left > 0) begin
            s_tvalid = 0;
            gap_left--;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata = {4'b0, smp, idx};
        s_tuser = first;
        s_tlast = last;
        do @(posedge aclk); while (!s_tready);
        sb.note_item(idx, smp, first, last);
        sent++;
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic write_register(reg_idx_t ri, logic [31:0] d);
        cfg_valid = 1;
        cfg_index = ri;
        cfg_data = d;
        do @(posedge aclk); while (!cfg_ready);
        sb.note_register(ri, d);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    // items without a result may still be in flight when the queue drains
    task automatic drain_pipeline();
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return sb.vmin[31:0];
            3: return sb.vmax[31:0];
            4: return 32'(sb.vmin - 1);
            5: return 32'(sb.vmax + 1);
            6: return 32'($signed($urandom_range(0, 400)) - 200);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [11:0] pick_pixel();
        if ($urandom_range(0, 2) == 0) return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(0, 15));
    endfunction

    task automatic random_traffic(int unsigned n);
        int unsigned goal, len, k;
        logic [11:0] p;
        bit first;
        goal = sent + n;
        while (sent < goal) begin
            p = pick_pixel();
            if ($urandom_range(0, 6) != 0) begin
                // well-formed layer stack, sometimes left open for a later phase
                len = $urandom_range(1, 6);
                first = !sb.cleared[p] || $urandom_range(0, 7) != 0;
                for (k = 0; k < len; k++)
                    send_sample(p, pick_sample(), first && k == 0,
                                k == len - 1 && $urandom_range(0, 5) != 0);
            end else begin
                send_sample(p, $urandom, !sb.cleared[p] || $urandom_range(0, 1),
                            $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int unsigned k;
        sb = new();
        repeat (2) @(negedge aclk);
        aresetn = 1;

        // directed: reset settings, full range mean
        send_sample(12'd0, 32'h7fffffff, 1, 1);
        send_sample(12'd4095, 32'h80000000, 1, 1);
        send_sample(12'd1, 32'hfffffff9, 1, 0);
        send_sample(12'd1, 32'h00000000, 0, 1);
        send_sample(12'd2, 32'h7fffffff, 1, 0);
        send_sample(12'd2, 32'h7fffffff, 0, 0);
        send_sample(12'd2, 32'h80000000, 0, 1);
        send_sample(12'd1, 32'h00000005, 1, 0);
        send_sample(12'd1, 32'h00000006, 1, 1);
        send_sample(12'd3, 32'h00010000, 1, 0);
        send_sample(12'd3, 32'h00020000, 0, 0);
        drain_pipeline();

        // directed: narrow range with invalid samples first
        write_register(REG_VMIN, 32'hffff0000);
        write_register(REG_VMAX, 32'h00010000);
        write_register(REG_MODE, MODE_MIN);
        send_sample(12'd3, 32'h00000100, 0, 1);
        send_sample(12'd4, 32'h00020000, 1, 0);
        send_sample(12'd4, 32'h7fffffff, 0, 1);
        send_sample(12'd5, 32'hfffe0000, 1, 0);
        send_sample(12'd5, 32'h00010000, 0, 0);
        send_sample(12'd5, 32'hffff0000, 0, 1);
        drain_pipeline();
        write_register(REG_MODE, MODE_MAX);
        send_sample(12'd6, 32'h00000003, 1, 0);
        send_sample(12'd6, 32'h00010000, 0, 0);
        send_sample(12'd6, 32'h00010001, 0, 1);
        drain_pipeline();
        write_register(REG_MODE, MODE_ALT);
        send_sample(12'd7, 32'h00000003, 1, 0);
        send_sample(12'd7, 32'hfffffffc, 0, 1);
        drain_pipeline();

        // count limit and extreme sum in mean mode
        write_register(REG_MODE, MODE_MEAN);
        write_register(REG_VMIN, 32'h80000000);
        write_register(REG_VMAX, 32'h7fffffff);
        for (k = 0; k < 1030; k++)
            send_sample(12'd100, ($urandom_range(0, 3) == 0) ? $urandom : 32'h80000000,
                        k == 0, k == 1029 || k == 1023);
        random_traffic(60);
        drain_pipeline();

        write_register(REG_MODE, MODE_MIN);
        write_register(REG_VMIN, 32'hffff8000);
        write_register(REG_VMAX, 32'h00008000);
        random_traffic(60);
        drain_pipeline();

        write_register(REG_MODE, MODE_MAX);
        write_register(REG_VMIN, 32'h7fffffff);
        write_register(REG_VMAX, 32'h7fffffff);
        random_traffic(50);
        drain_pipeline();

        // empty valid range
        write_register(REG_MODE, MODE_MEAN);
        write_register(REG_VMIN, 32'h00000001);
        write_register(REG_VMAX, 32'h00000000);
        random_traffic(40);
        drain_pipeline();

        write_register(REG_MODE, MODE_ALT);
        write_register(REG_VMIN, 32'h80000000);
        write_register(REG_VMAX, 32'h80000000);
        random_traffic(40);
        drain_pipeline();

        write_register(REG_MODE, MODE_MEAN);
        write_register(REG_VMAX, 32'h7fffffff);
        random_traffic(60);
        idle_on = 0;
        random_traffic(50);

        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
